/* hw/rtl/psc_pkg.sv */
// Shared constants, types and helper functions for the pot smoother / change detector.
package psc_pkg;

  localparam int MUX_COUNT        = 4;
  localparam int CHANNELS_PER_MUX = 16;
  localparam int STORE_DEPTH      = 64;
  localparam int KNOB_COUNT       = 56;
  localparam int ADDR_W           = $clog2(STORE_DEPTH);
  localparam int LEVEL_W          = 8;
  localparam int PERIOD_W         = 4;
  localparam int THRESH_W         = 8;
  localparam int CFG_W            = 8;
  localparam int CFG_IDX_W        = 1;

  // Channels that actually exist: limited by both the mux wiring and the store depth.
  localparam int CHAN_LIMIT = (MUX_COUNT * CHANNELS_PER_MUX < STORE_DEPTH) ?
                              MUX_COUNT * CHANNELS_PER_MUX : STORE_DEPTH;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 1'd1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Item that has issued its memory reads and waits for the data.
  typedef struct packed {
    logic               query;
    logic               skip;       // no memory access: bad knob or absent channel
    logic               bad;        // query for a knob beyond the wiring table
    logic [ADDR_W-1:0]  addr;
    logic [LEVEL_W-1:0] sample;     // reading with the two low bits dropped
    logic               snap_en;    // sample falls in a snapshot scan
    logic               sm_vld;     // smoothed entry written since reset
    logic               sm_fwd;     // smoothed entry written in the read cycle
    logic [LEVEL_W-1:0] sm_fwd_data;
    logic               sn_vld;
    logic               sn_fwd;
    logic [LEVEL_W-1:0] sn_fwd_data;
  } s1_t;

  // Write-back request toward both stores; they share one address.
  typedef struct packed {
    logic               sm_we;
    logic               sn_we;
    logic [ADDR_W-1:0]  addr;
    logic [LEVEL_W-1:0] sm_data;
    logic [LEVEL_W-1:0] sn_data;
  } wr_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   level;
    logic [LEVEL_W-2:0]   knob_level;
    logic                 changed;
    logic                 bad_index;
  } res_t;

  // Wiring table: the middle two mux banks are crossed, so swap bits 5 and 4.
  function automatic logic [ADDR_W-1:0] wiring_map(input logic [5:0] knob);
    return ADDR_W'({knob[4], knob[5], knob[3:0]});
  endfunction

endpackage

/* hw/rtl/psc_if.sv */
// Handshake interfaces for the item and result channels.
interface psc_item_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [5:0] channel;
  logic [9:0] raw_sample;
  logic       scan_start;
  logic [5:0] knob;

  modport source(output valid, req_type, channel, raw_sample, scan_start, knob,
                 input ready);
  modport sink(input valid, req_type, channel, raw_sample, scan_start, knob,
               output ready);
endinterface

interface psc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic [6:0] knob_level;
  logic       changed;
  logic       bad_index;

  modport source(output valid, level, knob_level, changed, bad_index, input ready);
  modport sink(input valid, level, knob_level, changed, bad_index, output ready);
endinterface

/* hw/rtl/psc_ram.sv */
// Generic single-write, single-read RAM with registered read data (read-first).
module psc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/psc_scan_ctrl.sv */
// Scan counter and snapshot-scan decision for incoming samples.
module psc_scan_ctrl
  import psc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,        // sample beat accepted
  input  logic                scan_start,
  input  logic [PERIOD_W-1:0] period,
  output logic                snap_en      // this sample copies into the snapshot
);

  logic [PERIOD_W-1:0] scan_count;
  logic [PERIOD_W-1:0] scan_count_next;
  logic [PERIOD_W-1:0] period_eff;

  // A period of zero behaves as one.
  assign period_eff = (period == '0) ? PERIOD_W'(1) : period;

  always_comb begin
    scan_count_next = scan_count;
    if (scan_start) begin
      if (scan_count >= period_eff) begin
        scan_count_next = PERIOD_W'(1);
      end else begin
        scan_count_next = scan_count + PERIOD_W'(1);
      end
    end
  end

  assign snap_en = (scan_count_next == period_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_count <= '0;
    end else if (step) begin
      scan_count <= scan_count_next;
    end
  end

endmodule

/* hw/rtl/psc_update.sv */
// Read-modify-write datapath: forward store data, average, compare, build write-back.
module psc_update
  import psc_pkg::*;
(
  input  s1_t                 s1,
  input  logic [LEVEL_W-1:0]  sm_rdata,
  input  logic [LEVEL_W-1:0]  sn_rdata,
  input  logic [THRESH_W-1:0] threshold,
  output wr_t                 wr,
  output res_t                res
);

  logic [LEVEL_W-1:0]   sm_cur;
  logic [LEVEL_W-1:0]   sn_cur;
  logic [LEVEL_W+2:0]   acc;
  logic [LEVEL_W-1:0]   avg;
  logic [LEVEL_W-1:0]   diff;
  logic                 chg;
  logic [LEVEL_W-1:0]   lvl;

  always_comb begin
    // Entry written in the read cycle beats the RAM; a never-written entry reads zero.
    if (s1.sm_fwd) begin
      sm_cur = s1.sm_fwd_data;
    end else if (s1.sm_vld) begin
      sm_cur = sm_rdata;
    end else begin
      sm_cur = '0;
    end
    if (s1.sn_fwd) begin
      sn_cur = s1.sn_fwd_data;
    end else if (s1.sn_vld) begin
      sn_cur = sn_rdata;
    end else begin
      sn_cur = '0;
    end

    // old*7 + new, then drop three bits
    acc  = {sm_cur, 3'b000} - {3'b000, sm_cur} + {3'b000, s1.sample};
    avg  = acc[LEVEL_W+2:3];
    diff = (sm_cur >= sn_cur) ? (sm_cur - sn_cur) : (sn_cur - sm_cur);
    chg  = (diff >= threshold);

    wr.addr    = s1.addr;
    wr.sm_we   = 1'b0;
    wr.sn_we   = 1'b0;
    wr.sm_data = avg;
    wr.sn_data = avg;
    lvl        = '0;
    res.changed = 1'b0;
    if (!s1.skip) begin
      if (s1.query) begin
        wr.sn_we    = chg;
        wr.sn_data  = sm_cur;
        lvl         = sm_cur;
        res.changed = chg;
      end else begin
        wr.sm_we = 1'b1;
        wr.sn_we = s1.snap_en;
        lvl      = avg;
      end
    end
    res.level      = lvl;
    res.knob_level = lvl[LEVEL_W-1:1];
    res.bad_index  = s1.bad;
  end

endmodule

/* hw/rtl/pot_smoother_change_detector_core.sv */
// Top level of the pot smoother / change detector: pipeline, stores and output register.
//
//  channel   dir  beat payload                                   notes
//  item      in   req_type, channel, raw_sample, scan_start,     sample or knob query
//                 knob
//  result    out  level, knob_level, changed, bad_index          one beat per item
//  wr_*      in   wr_index, wr_data                              threshold, snapshot period
//
// Throughput: one item per cycle while the result side keeps taking beats; a result goes
// from its item beat through the read cycle on the stores, then the update/write-back
// cycle into the output register. Both stores are 64x8 RAMs with registered reads.
// Reset: synchronous; clears the scan counter, the pipeline valids and the per-entry
// valid bits, so both stores read as zero at once with no clearing pass.
// Stalls: a full output register holds the update stage, which holds the item port.
module pot_smoother_change_detector_core
  import psc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  psc_item_if.sink             item,
  psc_result_if.source         result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  logic [THRESH_W-1:0] threshold;
  logic [PERIOD_W-1:0] period;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_W'(4);
      period    <= PERIOD_W'(10);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_THRESHOLD: threshold <= wr_data[THRESH_W-1:0];
        REG_PERIOD:    period    <= wr_data[PERIOD_W-1:0];
        default:       ;
      endcase
    end
  end

  // Pipeline handshake: output register, then update stage, then item port.
  logic s1_valid;
  logic out_valid;
  logic out_free;
  logic s1_adv;
  logic accept;

  assign out_free   = !out_valid || result.ready;
  assign s1_adv     = s1_valid && out_free;
  assign item.ready = !s1_valid || s1_adv;
  assign accept     = item.valid && item.ready;

  // Address stage: decode the item and issue the store reads.
  logic              is_query;
  logic              knob_bad;
  logic              chan_bad;
  logic [ADDR_W-1:0] s0_addr;
  logic              s0_skip;
  logic              snap_en;
  logic              rd_en;

  assign is_query = (item.req_type == REQ_QUERY);
  assign knob_bad = ({1'b0, item.knob} >= 7'(KNOB_COUNT));
  assign chan_bad = ({1'b0, item.channel} >= 7'(CHAN_LIMIT));
  assign s0_addr  = is_query ? wiring_map(item.knob) : ADDR_W'(item.channel);
  assign s0_skip  = is_query ? knob_bad : chan_bad;
  assign rd_en    = accept && !s0_skip;

  psc_scan_ctrl u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (accept && !is_query),
    .scan_start (item.scan_start),
    .period     (period),
    .snap_en    (snap_en)
  );

  // Stores and their valid bits.
  wr_t                wr;
  logic               sm_we;
  logic               sn_we;
  logic [LEVEL_W-1:0] sm_rdata;
  logic [LEVEL_W-1:0] sn_rdata;
  logic [STORE_DEPTH-1:0] sm_valid;
  logic [STORE_DEPTH-1:0] sn_valid;

  // Write back only when the update stage moves on.
  assign sm_we = s1_adv && wr.sm_we;
  assign sn_we = s1_adv && wr.sn_we;

  psc_ram #(.WIDTH(LEVEL_W), .DEPTH(STORE_DEPTH)) u_smoothed (
    .clk   (clk),
    .we    (sm_we),
    .waddr (wr.addr),
    .wdata (wr.sm_data),
    .re    (rd_en),
    .raddr (s0_addr),
    .rdata (sm_rdata)
  );

  psc_ram #(.WIDTH(LEVEL_W), .DEPTH(STORE_DEPTH)) u_snapshot (
    .clk   (clk),
    .we    (sn_we),
    .waddr (wr.addr),
    .wdata (wr.sn_data),
    .re    (rd_en),
    .raddr (s0_addr),
    .rdata (sn_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= '0;
      sn_valid <= '0;
    end else begin
      if (sm_we) begin
        sm_valid[wr.addr] <= 1'b1;
      end
      if (sn_we) begin
        sn_valid[wr.addr] <= 1'b1;
      end
    end
  end

  // Update stage register. The RAM reads first, so a write in the read cycle to the
  // same entry is captured here and forwarded.
  s1_t  s1;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.query       <= is_query;
      s1.skip        <= s0_skip;
      s1.bad         <= is_query && knob_bad;
      s1.addr        <= s0_addr;
      s1.sample      <= item.raw_sample[9:2];
      s1.snap_en     <= snap_en;
      s1.sm_vld      <= sm_valid[s0_addr];
      s1.sm_fwd      <= sm_we && (wr.addr == s0_addr);
      s1.sm_fwd_data <= wr.sm_data;
      s1.sn_vld      <= sn_valid[s0_addr];
      s1.sn_fwd      <= sn_we && (wr.addr == s0_addr);
      s1.sn_fwd_data <= wr.sn_data;
    end
  end

  psc_update u_update (
    .s1        (s1),
    .sm_rdata  (sm_rdata),
    .sn_rdata  (sn_rdata),
    .threshold (threshold),
    .wr        (wr),
    .res       (res)
  );

  // Output register: load on advance, drop the valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.level      <= res.level;
      result.knob_level <= res.knob_level;
      result.changed    <= res.changed;
      result.bad_index  <= res.bad_index;
    end
  end

  assign result.valid = out_valid;

endmodule

/* bench/tb.sv */
// Self-checking testbench for the pot smoother / change detector core.
module tb;
  import psc_pkg::*;

  // Cycles allowed with no beat on either channel before the run is declared hung.
  localparam int QUIET_LIMIT  = 1000;
  // Cycles to let the pipeline settle once nothing is expected any more.
  localparam int DRAIN_CYCLES = 6;
  // Length of the long receiver hold-off used to back the block up.
  localparam int HOLD_OFF_LEN = 60;
  localparam int SMOOTH_WEIGHT = 7;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;

  psc_item_if   item_bus();
  psc_result_if result_bus();

  pot_smoother_change_detector_core dut (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // Predicted block state: per-channel averages, snapshots, scan counter and registers.
  logic [LEVEL_W-1:0]  level_mem [STORE_DEPTH];
  logic [LEVEL_W-1:0]  snap_mem  [STORE_DEPTH];
  logic [PERIOD_W-1:0] scan_no;
  logic [THRESH_W-1:0] hyst_thresh;
  logic [PERIOD_W-1:0] snap_period;

  // Results owed by the block, oldest first.
  res_t levels_due[$];

  int  mismatches      = 0;
  int  hold_off_cycles = 0;
  bit  tx_jitter       = 1'b1;
  bit  rx_jitter       = 1'b1;
  int  aim [STORE_DEPTH];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Knob-to-channel wiring: the second and third mux banks are crossed.
  function automatic logic [5:0] knob_to_channel(input logic [5:0] kn);
    case (kn[5:4])
      2'd1: return kn + 6'd16;
      2'd2: return kn - 6'd16;
      default: return kn;
    endcase
  endfunction

  // Advance the predicted state by one item and return the result it owes.
  function automatic res_t smooth_and_detect(input logic req, input logic [5:0] ch,
                                             input logic [9:0] raw, input logic start,
                                             input logic [5:0] kn);
    res_t                r;
    logic [PERIOD_W-1:0] per;
    logic [10:0]         acc;
    logic [5:0]          phys;
    logic [LEVEL_W-1:0]  cur;
    logic [LEVEL_W-1:0]  old;
    logic [LEVEL_W-1:0]  diff;
    r = '0;
    // A period of zero behaves as one: every scan takes a snapshot.
    per = (snap_period == '0) ? PERIOD_W'(1) : snap_period;
    if (req == REQ_SAMPLE) begin
      // Scan start counts first; a counter above a lowered period restarts at one.
      if (start)
        scan_no = (scan_no >= per) ? PERIOD_W'(1) : scan_no + PERIOD_W'(1);
      if (int'(ch) < CHAN_LIMIT) begin
        acc = 11'(level_mem[ch]) * 11'(SMOOTH_WEIGHT) + 11'(raw[9:2]);
        level_mem[ch] = acc[10:3];
        if (scan_no == per)
          snap_mem[ch] = acc[10:3];
        r.level      = acc[10:3];
        r.knob_level = acc[10:4];
      end
    end else begin
      if (int'(kn) >= KNOB_COUNT) begin
        r.bad_index = 1'b1;
      end else begin
        phys = knob_to_channel(kn);
        cur  = level_mem[phys];
        old  = snap_mem[phys];
        diff = (cur >= old) ? cur - old : old - cur;
        // Movement at or past the threshold is a change and refreshes the snapshot.
        if (diff >= hyst_thresh) begin
          r.changed      = 1'b1;
          snap_mem[phys] = cur;
        end
        r.level      = cur;
        r.knob_level = cur[7:1];
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Offer one item, possibly after a short idle burst, and hold it until accepted.
  task automatic send_item(input logic req, input logic [5:0] ch, input logic [9:0] raw,
                           input logic start, input logic [5:0] kn);
    res_t owed;
    if (tx_jitter && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.req_type   <= req;
    item_bus.channel    <= ch;
    item_bus.raw_sample <= raw;
    item_bus.scan_start <= start;
    item_bus.knob       <= kn;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    // The beat went in at this edge: predict its result now.
    owed       = smooth_and_detect(req, ch, raw, start, kn);
    levels_due = {levels_due, owed};
  endtask

  // Drop valid and wait until every owed result has come out, then let the pipe settle.
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; the write lands at the next edge, together with the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: hyst_thresh = data;
      REG_PERIOD:    snap_period = data[PERIOD_W-1:0];
      default: ;
    endcase
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Field extremes, both knob errors, crossed wiring and dropped low bits, at reset settings.
  task automatic test_directed();
    send_item(REQ_QUERY,  6'd0,  10'd0,    1'b0, 6'd0);
    send_item(REQ_QUERY,  6'd63, 10'd1023, 1'b1, 6'd63);
    send_item(REQ_QUERY,  6'd0,  10'd0,    1'b0, 6'd56);
    send_item(REQ_SAMPLE, 6'd0,  10'd1023, 1'b1, 6'd0);
    send_item(REQ_SAMPLE, 6'd0,  10'd1023, 1'b0, 6'd63);
    send_item(REQ_SAMPLE, 6'd63, 10'd1023, 1'b0, 6'd0);
    send_item(REQ_SAMPLE, 6'd32, 10'd1020, 1'b0, 6'd0);
    send_item(REQ_QUERY,  6'd0,  10'd0,    1'b0, 6'd16);
    send_item(REQ_QUERY,  6'd0,  10'd0,    1'b0, 6'd16);
    send_item(REQ_SAMPLE, 6'd16, 10'd3,    1'b0, 6'd0);
    send_item(REQ_QUERY,  6'd0,  10'd0,    1'b0, 6'd32);
    send_item(REQ_SAMPLE, 6'd0,  10'd0,    1'b0, 6'd0);
    send_item(REQ_QUERY,  6'd0,  10'd0,    1'b0, 6'd55);
  endtask

  // Zero threshold flags every good query; the top threshold flags almost nothing.
  task automatic test_threshold_extremes();
    wait_idle();
    write_reg(REG_THRESHOLD, 8'd0);
    send_item(REQ_QUERY,  6'd0, 10'd0,    1'b0, 6'd0);
    send_item(REQ_QUERY,  6'd0, 10'd0,    1'b0, 6'd60);
    wait_idle();
    write_reg(REG_THRESHOLD, 8'd255);
    send_item(REQ_SAMPLE, 6'd5, 10'd1023, 1'b0, 6'd0);
    send_item(REQ_QUERY,  6'd0, 10'd0,    1'b0, 6'd5);
  endtask

  // Lower the period below the running scan count, then try period zero.
  task automatic test_period_changes();
    wait_idle();
    write_reg(REG_THRESHOLD, 8'd1);
    write_reg(REG_PERIOD, 8'd15);
    repeat (5) send_item(REQ_SAMPLE, 6'd7, 10'($urandom), 1'b1, 6'd0);
    wait_idle();
    write_reg(REG_PERIOD, 8'd2);
    send_item(REQ_SAMPLE, 6'd7, 10'd1023, 1'b1, 6'd0);
    send_item(REQ_SAMPLE, 6'd7, 10'd1023, 1'b1, 6'd0);
    send_item(REQ_QUERY,  6'd0, 10'd0,    1'b0, 6'd7);
    wait_idle();
    write_reg(REG_PERIOD, 8'd0);
    send_item(REQ_SAMPLE, 6'd9, 10'd800,  1'b1, 6'd0);
    send_item(REQ_QUERY,  6'd0, 10'd0,    1'b0, 6'd9);
  endtask

  // Hold the result side off for a long stretch while items keep coming back to back.
  task automatic test_output_stall();
    wait_idle();
    tx_jitter = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    for (int i = 0; i < 30; i++)
      send_item(REQ_SAMPLE, 6'(i % 3), 10'($urandom), 1'(i == 0), 6'd0);
    tx_jitter = 1'b1;
  endtask

  // Mostly well-formed scans over runs of channels near a drifting target, with queries
  // mixed in; the rest is unconstrained noise on every field.
  task automatic run_scans(input int count);
    int sent;
    int len;
    int first;
    int c;
    int r;
    int pick;
    sent = 0;
    while (sent < count) begin
      len   = $urandom_range(4, 16);
      first = $urandom_range(0, 63);
      for (int i = 0; i < len && sent < count; i++) begin
        pick = $urandom_range(0, 99);
        if (i > 0 && pick < 22) begin
          send_item(REQ_QUERY, 6'($urandom), 10'($urandom), 1'($urandom), 6'($urandom));
        end else if (i > 0 && pick < 28) begin
          send_item(REQ_SAMPLE, 6'($urandom), 10'($urandom), 1'($urandom), 6'($urandom));
        end else begin
          c = (first + i) % STORE_DEPTH;
          if ($urandom_range(0, 7) == 0)
            aim[c] = $urandom_range(0, 1023);
          r = aim[c] + int'($urandom_range(0, 32)) - 16;
          if (r < 0)
            r = 0;
          if (r > 1023)
            r = 1023;
          send_item(REQ_SAMPLE, 6'(c), 10'(r), 1'(i == 0), 6'($urandom));
        end
        sent++;
      end
    end
  endtask

  task automatic test_random_scans();
    for (int c = 0; c < STORE_DEPTH; c++)
      aim[c] = (c % 8 == 0) ? 1023 : (c % 8 == 1) ? 0 : int'($urandom_range(0, 1023));
    wait_idle();
    write_reg(REG_THRESHOLD, 8'd0);
    write_reg(REG_PERIOD, 8'd1);
    run_scans(150);
    wait_idle();
    write_reg(REG_THRESHOLD, 8'd1);
    write_reg(REG_PERIOD, 8'd15);
    run_scans(150);
    wait_idle();
    write_reg(REG_THRESHOLD, 8'd255);
    write_reg(REG_PERIOD, 8'd0);
    run_scans(150);
    wait_idle();
    write_reg(REG_THRESHOLD, 8'($urandom_range(2, 12)));
    write_reg(REG_PERIOD, 8'($urandom_range(1, 15)));
    run_scans(150);
    wait_idle();
    write_reg(REG_THRESHOLD, 8'd3);
    write_reg(REG_PERIOD, 8'd4);
    run_scans(150);
    // Close at full rate on both sides.
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    run_scans(150);
  endtask

  // Stimulus: reset once, then each test in turn, then drain and give the verdict.
  initial begin : stimulus
    for (int c = 0; c < STORE_DEPTH; c++) begin
      level_mem[c] = '0;
      snap_mem[c]  = '0;
    end
    scan_no     = '0;
    hyst_thresh = THRESH_W'(4);
    snap_period = PERIOD_W'(10);
    rst                 <= 1'b1;
    wr_en               <= 1'b0;
    wr_index            <= '0;
    wr_data             <= '0;
    item_bus.valid      <= 1'b0;
    item_bus.req_type   <= REQ_SAMPLE;
    item_bus.channel    <= '0;
    item_bus.raw_sample <= '0;
    item_bus.scan_start <= 1'b0;
    item_bus.knob       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_threshold_extremes();
    test_period_changes();
    test_output_stall();
    test_random_scans();
    item_bus.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Result side ready: honor a requested long hold-off, else short random idle bursts.
  initial begin : result_drain
    int n;
    result_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        result_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
        result_bus.ready <= 1'b1;
      end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Check every result beat against the oldest prediction; stop the run if nothing moves.
  initial begin : result_check
    int   quiet;
    res_t got;
    res_t want;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      quiet++;
      if (!rst && item_bus.valid && item_bus.ready)
        quiet = 0;
      if (!rst && result_bus.valid && result_bus.ready) begin
        quiet = 0;
        got.level      = result_bus.level;
        got.knob_level = result_bus.knob_level;
        got.changed    = result_bus.changed;
        got.bad_index  = result_bus.bad_index;
        if (levels_due.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing owed, level %0d", got.level));
        end else begin
          want = levels_due.pop_front();
          if (got.level !== want.level || got.knob_level !== want.knob_level ||
              got.changed !== want.changed || got.bad_index !== want.bad_index)
            flag_mismatch($sformatf(
              "level %0d exp %0d, knob_level %0d exp %0d, changed %b exp %b, bad %b exp %b",
              got.level, want.level, got.knob_level, want.knob_level,
              got.changed, want.changed, got.bad_index, want.bad_index));
        end
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/psc_pkg.sv
hw/rtl/psc_if.sv
hw/rtl/psc_ram.sv
hw/rtl/psc_scan_ctrl.sv
hw/rtl/psc_update.sv
hw/rtl/pot_smoother_change_detector_core.sv
bench/tb.sv
